// ----- hw/rtl/ffca_pkg.sv -----
`default_nettype none

package ffca_pkg;

    localparam int DATA_BYTES_W = 48;
    localparam int BIN_NUM_W    = 11;
    localparam int REM_W        = 32;
    localparam int IDX_W        = 10;
    localparam int AMT_W        = 32;
    localparam int HC_W         = 11;
    localparam logic [HC_W-1:0] HC_RESET = 11'd1024;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_ROOT  = 7'b0000100,
        ST_DOWN  = 7'b0001000,
        ST_LEAF  = 7'b0010000,
        ST_UP    = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic                 granted;
        logic [BIN_NUM_W-1:0] bin_number;
        logic [REM_W-1:0]     remaining;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ffca_tree_ram.sv -----
`default_nettype none

module ffca_tree_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 32
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ffca_walker.sv -----
`default_nettype none

module ffca_walker
    import ffca_pkg::*;
#(
    parameter int LEVELS = 10,
    parameter int CAP_WIDTH = 32,
    parameter int CNT_W = 11
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_op,
    input  wire logic [IDX_W-1:0]     in_idx,
    input  wire logic [CAP_WIDTH-1:0] in_amt,
    input  wire logic [CNT_W-1:0]     count,
    output logic                      done_valid,
    input  wire logic                 done_ack,
    output result_t                   result,
    output logic                      mem_we,
    output logic [LEVELS:0]           mem_waddr,
    output logic [CAP_WIDTH-1:0]      mem_wdata,
    output logic [LEVELS:0]           mem_raddr,
    input  wire logic [CAP_WIDTH-1:0] mem_rdata
);

    localparam int NODE_W = LEVELS + 1;
    localparam logic [NODE_W-1:0] LEAF_BASE = NODE_W'(1) << LEVELS;
    localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
    localparam logic [NODE_W-1:0] CLR_LAST  = '1;

    state_t                state_reg, state_next;
    logic [NODE_W-1:0]     node_reg, node_next;
    logic [NODE_W-1:0]     clr_reg, clr_next;
    logic [CAP_WIDTH-1:0]  val_reg, val_next;
    logic [CAP_WIDTH-1:0]  amt_reg, amt_next;
    result_t               res_reg, res_next;

    logic [NODE_W-1:0]     leaf_node;
    logic [NODE_W-1:0]     child;
    logic [NODE_W-1:0]     parent;
    logic [CNT_W-1:0]      bin;
    logic [CAP_WIDTH-1:0]  leaf_new;
    logic [CAP_WIDTH-1:0]  up_max;

    assign in_ready   = (state_reg == ST_IDLE);
    assign done_valid = (state_reg == ST_DONE);
    assign result     = res_reg;

    assign leaf_node = LEAF_BASE | NODE_W'(in_idx);
    assign parent    = node_reg >> 1;
    assign bin       = CNT_W'(node_reg ^ LEAF_BASE);
    assign leaf_new  = val_reg - amt_reg;
    assign up_max    = (mem_rdata > val_reg) ? mem_rdata : val_reg;

    always_comb
    begin
        state_next = state_reg;
        node_next  = node_reg;
        clr_next   = clr_reg;
        val_next   = val_reg;
        amt_next   = amt_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = node_reg;
        mem_wdata  = val_reg;
        mem_raddr  = '0;
        child      = node_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + NODE_W'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    amt_next = in_amt;
                    if (in_op == OP_LOAD)
                    begin
                        if (CNT_W'(in_idx) < count)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = leaf_node;
                            mem_wdata = in_amt;
                            mem_raddr = leaf_node ^ NODE_W'(1);
                            node_next = leaf_node;
                            val_next  = in_amt;
                            state_next = (leaf_node == ROOT) ? ST_DONE : ST_UP;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    else if (count == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_raddr  = ROOT;
                        node_next  = ROOT;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                val_next = mem_rdata;
                if (mem_rdata < amt_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (LEVELS == 0)
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    mem_raddr  = NODE_W'({node_reg, 1'b0});
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN:
            begin
                if (mem_rdata >= amt_reg)
                begin
                    child    = NODE_W'({node_reg, 1'b0});
                    val_next = mem_rdata;
                end
                else
                begin
                    child = NODE_W'({node_reg, 1'b1});
                end
                node_next = child;
                if ((child & LEAF_BASE) != '0)
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    mem_raddr = NODE_W'({child, 1'b0});
                end
            end
            ST_LEAF:
            begin
                if (bin >= count)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = node_reg;
                    mem_wdata = leaf_new;
                    mem_raddr = node_reg ^ NODE_W'(1);
                    val_next  = leaf_new;
                    res_next.granted    = 1'b1;
                    res_next.bin_number = BIN_NUM_W'(bin + CNT_W'(1));
                    res_next.remaining  = REM_W'(64'(leaf_new));
                    state_next = (node_reg == ROOT) ? ST_DONE : ST_UP;
                end
            end
            ST_UP:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = up_max;
                mem_raddr = parent ^ NODE_W'(1);
                node_next = parent;
                val_next  = up_max;
                if (parent == ROOT)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (done_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        val_reg  <= val_next;
        amt_reg  <= amt_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/first_fit_capacity_allocator_unit.sv -----
// First-fit capacity allocator on a binary max tree held in one RAM.
// Input stream s_*: s_tuser is op (0 load, 1 request); s_tdata carries
// bin_index and amount. Output stream m_*: one item per input item,
// m_tuser is granted, m_tdata carries bin_number and remaining.
// cfg_* writes hotel_count (bins in use); write only while idle.
// One item is in work at a time; the walker reads and writes the tree RAM
// once per level. A load writes its leaf and then walks leaf-to-root; a
// request walks root-to-leaf (LEVELS = clog2(BIN_SLOTS)) and then back up.
// A load beyond the count or a request refused at the root finishes
// without walking the tree; a request whose first fit lies beyond the count
// is refused at the leaf.
// After reset the RAM is cleared one entry a cycle, all 2*2^LEVELS entries
// (2048 at 1024 bins); s_tready stays low until that pass is done.
// hotel_count resets to 1024.
// The result waits in an output register; a new item is accepted while it
// waits, and the walker holds its next result until m_tready frees the
// register.
`default_nettype none

module first_fit_capacity_allocator_unit
    import ffca_pkg::*;
#(
    parameter int BIN_SLOTS = 1024,
    parameter int CAP_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // [9:0] bin_index, [41:10] amount
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [10:0] bin_number, [42:11] remaining
    output logic             m_tuser,   // [0] granted
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [10:0] cfg_data
);

    localparam int LEVELS = $clog2(BIN_SLOTS);
    localparam int CNT_W  = ($clog2(BIN_SLOTS + 1) > HC_W) ? $clog2(BIN_SLOTS + 1) : HC_W;

    logic [HC_W-1:0]      hc_reg;
    logic [CNT_W-1:0]     count;
    logic [63:0]          amt_wide;
    logic [CAP_WIDTH-1:0] amt;
    logic                 done_valid;
    logic                 done_ack;
    result_t              result;
    result_t              out_reg;
    logic                 out_valid_reg;

    logic                 mem_we;
    logic [LEVELS:0]      mem_waddr;
    logic [LEVELS:0]      mem_raddr;
    logic [CAP_WIDTH-1:0] mem_wdata;
    logic [CAP_WIDTH-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign count     = (32'(hc_reg) > 32'(BIN_SLOTS)) ? CNT_W'(BIN_SLOTS) : CNT_W'(hc_reg);
    assign amt_wide  = 64'(s_tdata[41:10]);
    assign amt       = amt_wide[CAP_WIDTH-1:0];
    assign done_ack  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg        <= HC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                hc_reg <= cfg_data;
            end
            if (done_valid && done_ack)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_valid && done_ack)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.granted;
    assign m_tdata  = {5'b0, out_reg.remaining, out_reg.bin_number};

    ffca_walker #(
        .LEVELS    (LEVELS),
        .CAP_WIDTH (CAP_WIDTH),
        .CNT_W     (CNT_W)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_idx     (s_tdata[9:0]),
        .in_amt     (amt),
        .count      (count),
        .done_valid (done_valid),
        .done_ack   (done_ack),
        .result     (result),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    ffca_tree_ram #(
        .ADDR_W (LEVELS + 1),
        .DATA_W (CAP_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/ffca_checker.sv -----
`default_nettype none

module ffca_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output item dropped while stalled");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[42:0] == 43'd0)
        else $error("non-granted item carries nonzero fields");

    a_granted_bin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[10:0] != 11'd0)
        else $error("granted item without bin number");

    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready && !m_tvalid)
        else $error("block active during clearing pass");

endmodule

bind first_fit_capacity_allocator_unit ffca_checker u_ffca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
